// ===== rtl/lhec_pkg.sv =====
package lhec_pkg;

  localparam int ENTRIES_DEF  = 1024;
  localparam int KEY_BITS_DEF = 32;

  localparam int KEY_IN_BITS = 32;
  localparam int COUNT_BITS  = 32;
  localparam int TIME_BITS   = 32;
  localparam int SLOT_BITS   = 10;
  localparam int CAP_BITS    = 11;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 11'd1000;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_PROBE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } lhec_state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
  } lhec_cmd_t;

  typedef struct packed {
    logic scan_done;
  } lhec_sts_t;

endpackage

// ===== rtl/lhec_ram.sv =====
module lhec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lhec_ctrl.sv =====
module lhec_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  lhec_pkg::lhec_sts_t sts_i,
  output logic               busy,
  output lhec_pkg::lhec_cmd_t cmd_o
);

  import lhec_pkg::*;

  lhec_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign cmd_o.load   = (state_q == ST_IDLE) && start;
  assign cmd_o.scan   = (state_q == ST_SCAN);
  assign cmd_o.decide = (state_q == ST_DECIDE);

endmodule

// ===== rtl/lhec_dp.sv =====
module lhec_dp #(
  parameter int ENTRIES  = lhec_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lhec_pkg::KEY_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lhec_pkg::lhec_cmd_t              cmd_i,
  output lhec_pkg::lhec_sts_t              sts_o,
  input  logic                             cfg_valid_i,
  input  logic [lhec_pkg::CAP_BITS-1:0]    cfg_data_i,
  input  logic                             command_i,
  input  logic [lhec_pkg::KEY_IN_BITS-1:0] concept_key_i,
  input  logic [lhec_pkg::TIME_BITS-1:0]   timestamp_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic                             evicted_o,
  output logic [lhec_pkg::KEY_IN_BITS-1:0] evicted_key_o,
  output logic [lhec_pkg::SLOT_BITS-1:0]   slot_o,
  output logic [lhec_pkg::COUNT_BITS-1:0]  use_count_o
);

  import lhec_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int SK_W  = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
  localparam int CMP_W = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;
  localparam int WORD_W = SK_W + COUNT_BITS + TIME_BITS;

  logic [CAP_BITS-1:0]   cap_q;
  logic [OCC_W-1:0]      occ_q, occ_d;
  logic                  cmd_q;
  logic [SK_W-1:0]       key_q;
  logic [TIME_BITS-1:0]  time_q;
  logic [OCC_W-1:0]      addr_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  found_q;
  logic [IDX_W-1:0]      found_idx_q;
  logic [COUNT_BITS-1:0] found_cnt_q;
  logic                  have_min_q;
  logic [IDX_W-1:0]      min_idx_q;
  logic [COUNT_BITS-1:0] min_cnt_q;
  logic [SK_W-1:0]       min_key_q;

  logic                  done_q;
  logic                  hit_q, hit_d;
  logic                  evicted_q, evicted_d;
  logic [SK_W-1:0]       evk_q, evk_d;
  logic [IDX_W-1:0]      slot_q, slot_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  logic                  rd_en;
  logic [WORD_W-1:0]     rdata;
  logic [SK_W-1:0]       rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [WORD_W-1:0]     wdata;
  logic [CMP_W-1:0]      eff_cap;
  logic                  full;

  assign rd_en  = cmd_i.scan && (addr_q < occ_q);
  assign rd_key = rdata[WORD_W-1 -: SK_W];
  assign rd_cnt = rdata[TIME_BITS +: COUNT_BITS];
  assign sts_o.scan_done = cmd_i.scan && !rd_en && !rd_vld_q;

  lhec_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (addr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    eff_cap = CMP_W'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (eff_cap > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end
  end

  assign full = (CMP_W'(occ_q) >= eff_cap);

  always_comb begin
    hit_d     = 1'b0;
    evicted_d = 1'b0;
    evk_d     = '0;
    slot_d    = '0;
    count_d   = '0;
    occ_d     = occ_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = {key_q, COUNT_BITS'(1), time_q};
    if (found_q) begin
      hit_d   = 1'b1;
      slot_d  = found_idx_q;
      count_d = found_cnt_q;
      if (cmd_q == CMD_ACCESS) begin
        if (found_cnt_q != '1) begin
          count_d = found_cnt_q + COUNT_BITS'(1);
        end
        we    = cmd_i.decide;
        waddr = found_idx_q;
        wdata = {key_q, count_d, time_q};
      end
    end else if (cmd_q == CMD_ACCESS) begin
      count_d = COUNT_BITS'(1);
      we      = cmd_i.decide;
      if (full && have_min_q) begin
        evicted_d = 1'b1;
        evk_d     = min_key_q;
        slot_d    = min_idx_q;
      end else begin
        slot_d = occ_q[IDX_W-1:0];
        occ_d  = occ_q + OCC_W'(1);
      end
      waddr = slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CAP_RESET;
      occ_q      <= '0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      have_min_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.decide;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        addr_q     <= '0;
        rd_vld_q   <= 1'b0;
        found_q    <= 1'b0;
        have_min_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_vld_q <= rd_en;
        if (rd_en) begin
          addr_q <= addr_q + OCC_W'(1);
        end
        if (rd_vld_q) begin
          if (!found_q && (rd_key == key_q)) begin
            found_q <= 1'b1;
          end
          if (!have_min_q || (rd_cnt < min_cnt_q)) begin
            have_min_q <= 1'b1;
          end
        end
      end
      if (cmd_i.decide) begin
        occ_q <= occ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      key_q  <= SK_W'(concept_key_i);
      time_q <= timestamp_i;
    end
    if (cmd_i.scan) begin
      rd_idx_q <= addr_q[IDX_W-1:0];
      if (rd_vld_q) begin
        if (!found_q && (rd_key == key_q)) begin
          found_idx_q <= rd_idx_q;
          found_cnt_q <= rd_cnt;
        end
        if (!have_min_q || (rd_cnt < min_cnt_q)) begin
          min_idx_q <= rd_idx_q;
          min_cnt_q <= rd_cnt;
          min_key_q <= rd_key;
        end
      end
    end
    if (cmd_i.decide) begin
      hit_q     <= hit_d;
      evicted_q <= evicted_d;
      evk_q     <= evk_d;
      slot_q    <= slot_d;
      count_q   <= count_d;
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = KEY_IN_BITS'(evk_q);
  assign slot_o        = SLOT_BITS'(slot_q);
  assign use_count_o   = count_q;

endmodule

// ===== rtl/lfu_hot_entry_cache.sv =====
// Start is taken in idle; the scan then reads every filled slot of the table RAM through its
// one read port, the decide state writes the entry on an access, and done_o is registered
// from the decide state. A new word is taken only in idle, so each word is finished first.
// The receiver cannot stall; a new start is taken in the cycle the result is shown.
// Reset is asynchronous and active low; it empties the table through the count, capacity 1000.
module lfu_hot_entry_cache #(
  parameter int ENTRIES  = lhec_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lhec_pkg::KEY_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lhec_pkg::CAP_BITS-1:0]    cfg_data_i,
  input  logic                             command_i,
  input  logic [lhec_pkg::KEY_IN_BITS-1:0] concept_key_i,
  input  logic [lhec_pkg::TIME_BITS-1:0]   timestamp_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic                             evicted_o,
  output logic [lhec_pkg::KEY_IN_BITS-1:0] evicted_key_o,
  output logic [lhec_pkg::SLOT_BITS-1:0]   slot_o,
  output logic [lhec_pkg::COUNT_BITS-1:0]  use_count_o
);

  import lhec_pkg::*;

  lhec_cmd_t cmd;
  lhec_sts_t sts;

  assign cfg_ready_o = !busy;

  lhec_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  lhec_dp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .concept_key_i (concept_key_i),
    .timestamp_i   (timestamp_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o),
    .slot_o        (slot_o),
    .use_count_o   (use_count_o)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_o) |-> (!hit_o && (use_count_o == 32'd1)))
    else $error("eviction reported on a hit or with a wrong count");

  a_no_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !evicted_o) |-> (evicted_key_o == '0))
    else $error("evicted key without an eviction");

  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
`endif

endmodule
